// ----- rtl/tdc_pkg.sv -----
package tdc_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STAGES   = 20;
    localparam int ACCEL_W         = 16;
    localparam int MAXW            = 7;
    localparam int FSW             = 14;
    localparam int CMDW            = 15;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = FSW;
    localparam int PRESCALE_BITS   = 30;
    localparam int OPW             = ACCEL_W + 1;
    localparam int AW              = OPW + PRESCALE_BITS + 2;
    localparam int ZW              = ANGLE_FRAC_BITS + 10;
    localparam int QB              = FSW;
    localparam int DW              = MAXW + FSW + 1;
    localparam int PW              = ZW + FSW + 1;
    localparam int NW              = PW - ANGLE_FRAC_BITS;
    localparam int CORDIC_LAT      = CORDIC_STAGES + 1;
    localparam int SCALE_LAT       = QB + 3;
    localparam int BACK_LAT        = CORDIC_LAT + SCALE_LAT;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 1'b1;

    localparam logic [MAXW-1:0] MAX_ANGLE_RESET  = 7'd60;
    localparam logic [FSW-1:0]  FULL_SCALE_RESET = 14'd1000;

    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180) << ANGLE_FRAC_BITS;

    localparam logic [63:0] DEG_PER_RAD_Q32 = 64'd246083499208;

    typedef struct packed {
        logic signed [OPW-1:0] den;
        logic signed [OPW-1:0] num_x;
        logic signed [OPW-1:0] num_y;
        logic signed [ZW-1:0]  z0_x;
        logic signed [ZW-1:0]  z0_y;
        logic                  zero_x;
        logic                  zero_y;
        logic                  upside;
    } tdc_work_t;

    function automatic logic signed [ZW-1:0] stage_angle(input int i);
        logic [63:0] q32;
        logic [63:0] r;
        int s;
        s = 32 - ANGLE_FRAC_BITS;
        case (i)
            0:  q32 = 64'd193273528320;
            1:  q32 = 64'd114096026022;
            2:  q32 = 64'd60285206652;
            3:  q32 = 64'd30601712202;
            4:  q32 = 64'd15360239180;
            5:  q32 = 64'd7687607525;
            6:  q32 = 64'd3844741810;
            7:  q32 = 64'd1922488225;
            8:  q32 = 64'd961258780;
            9:  q32 = 64'd480631223;
            10: q32 = 64'd240315841;
            11: q32 = 64'd120157949;
            12: q32 = 64'd60078978;
            13: q32 = 64'd30039490;
            default: q32 = (DEG_PER_RAD_Q32 + (64'd1 << (i - 1))) >> i;
        endcase
        r = (q32 + (64'd1 << (s - 1))) >> s;
        return ZW'(r);
    endfunction

endpackage

// ----- rtl/tdc_in_if.sv -----
interface tdc_in_if;
    import tdc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

// ----- rtl/tdc_out_if.sv -----
interface tdc_out_if;
    import tdc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [CMDW-1:0] drive_cmd;
    logic signed [CMDW-1:0] turn_cmd;
    logic                   upside_down;

    modport source (output valid, output drive_cmd, output turn_cmd, output upside_down,
                    input ready);
    modport sink   (input valid, input drive_cmd, input turn_cmd, input upside_down,
                    output ready);
endinterface

// ----- rtl/tdc_front.sv -----
module tdc_front (
    input  logic                clk,
    input  logic                rst_n,
    tdc_in_if.sink              sample,
    input  logic                push_ok,
    output logic                work_valid,
    output tdc_pkg::tdc_work_t  work
);
    import tdc_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    tdc_work_t work_reg;
    tdc_work_t work_next;
    logic      take;

    assign sample.ready = !valid_reg || push_ok;
    assign take         = sample.valid && sample.ready;

    always_comb
    begin
        work_next.zero_x = (sample.accel_x == '0) && (sample.accel_z == '0);
        work_next.zero_y = (sample.accel_y == '0) && (sample.accel_z == '0);
        work_next.upside = sample.accel_z < 0;
        if (sample.accel_z < 0)
        begin
            work_next.den   = -OPW'(sample.accel_z);
            work_next.num_x = -OPW'(sample.accel_x);
            work_next.num_y = -OPW'(sample.accel_y);
            work_next.z0_x  = (sample.accel_x >= 0) ? HALF_TURN : -HALF_TURN;
            work_next.z0_y  = (sample.accel_y >= 0) ? HALF_TURN : -HALF_TURN;
        end
        else
        begin
            work_next.den   = OPW'(sample.accel_z);
            work_next.num_x = OPW'(sample.accel_x);
            work_next.num_y = OPW'(sample.accel_y);
            work_next.z0_x  = '0;
            work_next.z0_y  = '0;
        end
    end

    assign valid_next = take || (valid_reg && !push_ok);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            work_reg <= work_next;
        end
    end

    assign work_valid = valid_reg;
    assign work       = work_reg;
endmodule

// ----- rtl/tdc_fifo.sv -----
module tdc_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tdc_pkg::tdc_work_t push_data,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output tdc_pkg::tdc_work_t head
);
    import tdc_pkg::*;

    tdc_work_t  mem_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ----- rtl/tdc_cordic.sv -----
module tdc_cordic (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [tdc_pkg::OPW-1:0]       den,
    input  logic signed [tdc_pkg::OPW-1:0]       num,
    input  logic signed [tdc_pkg::ZW-1:0]        z0,
    input  logic                                 zero,
    output logic signed [tdc_pkg::ZW-1:0]        angle
);
    import tdc_pkg::*;

    logic signed [AW-1:0] a_reg    [0:CORDIC_STAGES];
    logic signed [AW-1:0] b_reg    [0:CORDIC_STAGES];
    logic signed [ZW-1:0] z_reg    [0:CORDIC_STAGES];
    logic                 zero_reg [0:CORDIC_STAGES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0]    <= AW'(den) <<< PRESCALE_BITS;
            b_reg[0]    <= AW'(num) <<< PRESCALE_BITS;
            z_reg[0]    <= z0;
            zero_reg[0] <= zero;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        localparam logic signed [ZW-1:0] STEP = stage_angle(i);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (b_reg[i] >= 0)
                begin
                    a_reg[i+1] <= a_reg[i] + (b_reg[i] >>> i);
                    b_reg[i+1] <= b_reg[i] - (a_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + STEP;
                end
                else
                begin
                    a_reg[i+1] <= a_reg[i] - (b_reg[i] >>> i);
                    b_reg[i+1] <= b_reg[i] + (a_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - STEP;
                end
            end
        end
    end

    assign angle = zero_reg[CORDIC_STAGES] ? '0 : z_reg[CORDIC_STAGES];
endmodule

// ----- rtl/tdc_scale.sv -----
module tdc_scale (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [tdc_pkg::ZW-1:0]     angle,
    input  logic                              negate,
    input  logic [tdc_pkg::MAXW-1:0]          max_angle_deg,
    input  logic [tdc_pkg::FSW-1:0]           full_scale,
    output logic signed [tdc_pkg::CMDW-1:0]   cmd
);
    import tdc_pkg::*;

    logic [ZW-1:0]        mag;
    logic [ZW-1:0]        lim;
    logic signed [PW-1:0] prod_reg;
    logic                 sat0_reg;
    logic                 pos0_reg;
    logic                 neg0_reg;
    logic signed [NW-1:0] n_val;
    logic [NW-1:0]        n_abs;

    logic [DW-1:0] rem_reg [0:QB];
    logic [QB-1:0] q_reg   [0:QB];
    logic          sat_reg [0:QB];
    logic          pos_reg [0:QB];
    logic          neg_reg [0:QB];

    logic [QB:0]            q_adj;
    logic signed [CMDW-1:0] fs_s;
    logic signed [CMDW-1:0] res;
    logic signed [CMDW-1:0] cmd_reg;

    assign mag = (angle < 0) ? ZW'(-angle) : ZW'(angle);
    assign lim = ZW'(max_angle_deg) << ANGLE_FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PW'(angle) * PW'($signed({1'b0, full_scale}));
            sat0_reg <= !(mag < lim);
            pos0_reg <= angle > 0;
            neg0_reg <= angle < 0;
        end
    end

    assign n_val = NW'(prod_reg >>> ANGLE_FRAC_BITS);
    assign n_abs = (n_val < 0) ? NW'(-n_val) : NW'(n_val);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DW'(n_abs);
            q_reg[0]   <= '0;
            sat_reg[0] <= sat0_reg;
            pos_reg[0] <= pos0_reg;
            neg_reg[0] <= neg0_reg;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_div
        localparam int J = QB - 1 - k;
        logic [DW-1:0] step;
        assign step = DW'(max_angle_deg) << J;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sat_reg[k+1] <= sat_reg[k];
                pos_reg[k+1] <= pos_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                if (rem_reg[k] >= step)
                begin
                    rem_reg[k+1] <= rem_reg[k] - step;
                    q_reg[k+1]   <= q_reg[k] | (QB'(1) << J);
                end
                else
                begin
                    rem_reg[k+1] <= rem_reg[k];
                    q_reg[k+1]   <= q_reg[k];
                end
            end
        end
    end

    always_comb
    begin
        q_adj = {1'b0, q_reg[QB]};
        if (neg_reg[QB] && (rem_reg[QB] != '0))
        begin
            q_adj = q_adj + (QB+1)'(1);
        end
        fs_s = CMDW'(full_scale);
        if (sat_reg[QB])
        begin
            res = pos_reg[QB] ? fs_s : -fs_s;
        end
        else
        begin
            res = neg_reg[QB] ? -CMDW'(q_adj) : CMDW'(q_adj);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd_reg <= negate ? -res : res;
        end
    end

    assign cmd = cmd_reg;
endmodule

// ----- rtl/tdc_back.sv -----
module tdc_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     work_valid,
    input  tdc_pkg::tdc_work_t       work,
    output logic                     pop,
    input  logic [tdc_pkg::MAXW-1:0] max_angle_deg,
    input  logic [tdc_pkg::FSW-1:0]  full_scale,
    tdc_out_if.source                command
);
    import tdc_pkg::*;

    logic                 en;
    logic                 valid_reg  [0:BACK_LAT-1];
    logic                 upside_reg [0:BACK_LAT-1];
    logic signed [ZW-1:0] pitch;
    logic signed [ZW-1:0] roll;

    assign en  = !valid_reg[BACK_LAT-1] || command.ready;
    assign pop = en && work_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BACK_LAT; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= work_valid;
            for (int i = 1; i < BACK_LAT; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            upside_reg[0] <= work.upside;
            for (int i = 1; i < BACK_LAT; i++)
            begin
                upside_reg[i] <= upside_reg[i-1];
            end
        end
    end

    tdc_cordic u_cordic_pitch (
        .clk   (clk),
        .en    (en),
        .den   (work.den),
        .num   (work.num_x),
        .z0    (work.z0_x),
        .zero  (work.zero_x),
        .angle (pitch)
    );

    tdc_cordic u_cordic_roll (
        .clk   (clk),
        .en    (en),
        .den   (work.den),
        .num   (work.num_y),
        .z0    (work.z0_y),
        .zero  (work.zero_y),
        .angle (roll)
    );

    tdc_scale u_scale_drive (
        .clk           (clk),
        .en            (en),
        .angle         (pitch),
        .negate        (1'b1),
        .max_angle_deg (max_angle_deg),
        .full_scale    (full_scale),
        .cmd           (command.drive_cmd)
    );

    tdc_scale u_scale_turn (
        .clk           (clk),
        .en            (en),
        .angle         (roll),
        .negate        (1'b0),
        .max_angle_deg (max_angle_deg),
        .full_scale    (full_scale),
        .cmd           (command.turn_cmd)
    );

    assign command.valid       = valid_reg[BACK_LAT-1];
    assign command.upside_down = upside_reg[BACK_LAT-1];
endmodule

// ----- rtl/tilt_to_drive_command_core.sv -----
// Tilt to drive command: each accelerometer sample (x, y, z) becomes pitch =
// atan2(x, z) and roll = atan2(y, z) in degrees (16 fraction bits, 20-stage
// vectoring CORDIC), scaled to a drive command (negated pitch) and a turn
// command (roll), each scaled angle floored and clamped to +-full_scale at
// max_angle_deg before the drive negation, plus a flag for negative z. One
// sample is accepted per clock while the queue is not full; a result passes
// through the front register, the queue, the CORDIC pipeline and the
// one-bit-per-stage divider by max_angle_deg. A stalled command holds the back.
// Write max_angle_deg and full_scale only while no sample is in flight.
module tilt_to_drive_command_core (
    input  logic                          clk,
    input  logic                          rst_n,
    tdc_in_if.sink                        sample,
    tdc_out_if.source                     command,
    input  logic                          cfg_we,
    input  logic [tdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tdc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tdc_pkg::*;

    logic [MAXW-1:0] max_angle_reg;
    logic [FSW-1:0]  full_scale_reg;
    logic            work_valid;
    tdc_work_t       work;
    logic            fifo_full;
    logic            fifo_not_empty;
    tdc_work_t       fifo_head;
    logic            pop;
    logic            push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_angle_reg  <= MAX_ANGLE_RESET;
            full_scale_reg <= FULL_SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_ANGLE:  max_angle_reg  <= cfg_data[MAXW-1:0];
                REG_FULL_SCALE: full_scale_reg <= cfg_data[FSW-1:0];
                default:        ;
            endcase
        end
    end

    assign push = work_valid && !fifo_full;

    tdc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .push_ok    (!fifo_full),
        .work_valid (work_valid),
        .work       (work)
    );

    tdc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (work),
        .full      (fifo_full),
        .pop       (pop),
        .not_empty (fifo_not_empty),
        .head      (fifo_head)
    );

    tdc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .work_valid    (fifo_not_empty),
        .work          (fifo_head),
        .pop           (pop),
        .max_angle_deg (max_angle_reg),
        .full_scale    (full_scale_reg),
        .command       (command)
    );
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import tdc_pkg::*;

    localparam int PIPE_DRAIN  = 60;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 1900;

    typedef struct {
        logic signed [CMDW-1:0] drive_cmd;
        logic signed [CMDW-1:0] turn_cmd;
        logic                   upside_down;
    } command_t;

    class tilt_scoreboard;
        command_t     pending[$];
        longint       angle_step[CORDIC_STAGES];
        longint       max_angle;
        longint       full_scale;
        int           errors;

        function new();
            longint unsigned q32;
            longint unsigned atan_q32[14] = '{
                64'd193273528320, 64'd114096026022, 64'd60285206652, 64'd30601712202,
                64'd15360239180, 64'd7687607525, 64'd3844741810, 64'd1922488225,
                64'd961258780, 64'd480631223, 64'd240315841, 64'd120157949,
                64'd60078978, 64'd30039490};
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                if (i < 14)
                    q32 = atan_q32[i];
                else
                    q32 = (64'd246083499208 + (64'd1 << (i - 1))) >> i;
                angle_step[i] = longint'((q32 + (64'd1 << (31 - ANGLE_FRAC_BITS)))
                                         >> (32 - ANGLE_FRAC_BITS));
            end
            max_angle  = 60;
            full_scale = 1000;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_MAX_ANGLE)
                max_angle = longint'(data[MAXW-1:0]);
            else if (idx == REG_FULL_SCALE)
                full_scale = longint'(data[FSW-1:0]);
        endfunction

        function longint tilt(longint num, longint den);
            longint a, b, z, da, db;
            z = 0;
            if (num == 0 && den == 0)
                return 0;
            a = den * (longint'(1) << 30);
            b = num * (longint'(1) << 30);
            if (a < 0)
            begin
                z = (num >= 0) ? (longint'(180) << ANGLE_FRAC_BITS)
                               : -(longint'(180) << ANGLE_FRAC_BITS);
                a = -a;
                b = -b;
            end
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                da = b >>> i;
                db = a >>> i;
                if (b >= 0)
                begin
                    a += da;
                    b -= db;
                    z += angle_step[i];
                end
                else
                begin
                    a -= da;
                    b += db;
                    z -= angle_step[i];
                end
            end
            return z;
        endfunction

        function longint scaled(longint ang);
            longint lim, mag, n, q;
            lim = max_angle << ANGLE_FRAC_BITS;
            mag = ang < 0 ? -ang : ang;
            if (mag < lim)
            begin
                n = ang * full_scale;
                if (n >= 0)
                    q = n / lim;
                else
                    q = -((-n + lim - 1) / lim);
                return q;
            end
            return ang > 0 ? full_scale : -full_scale;
        endfunction

        function void note(logic signed [ACCEL_W-1:0] x, logic signed [ACCEL_W-1:0] y,
                           logic signed [ACCEL_W-1:0] z);
            command_t c;
            longint pitch, roll, drive;
            pitch = tilt(longint'(x), longint'(z));
            roll  = tilt(longint'(y), longint'(z));
            drive = -scaled(pitch);
            c.drive_cmd   = CMDW'(drive);
            c.turn_cmd    = CMDW'(scaled(roll));
            c.upside_down = z < 0;
            pending.push_back(c);
        endfunction

        function void check(command_t got);
            command_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected command beat drive=%0d turn=%0d", got.drive_cmd,
                       got.turn_cmd);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.drive_cmd !== want.drive_cmd)
            begin
                $error("drive_cmd expected %0d actual %0d", want.drive_cmd, got.drive_cmd);
                errors++;
            end
            if (got.turn_cmd !== want.turn_cmd)
            begin
                $error("turn_cmd expected %0d actual %0d", want.turn_cmd, got.turn_cmd);
                errors++;
            end
            if (got.upside_down !== want.upside_down)
            begin
                $error("upside_down expected %0b actual %0b", want.upside_down,
                       got.upside_down);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    calm;
    int                    gap_odds;
    int                    stall_odds;
    int unsigned           cycles;
    tilt_scoreboard        sb;

    tdc_in_if  sample_if();
    tdc_out_if command_if();

    tilt_to_drive_command_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample_if.sink),
        .command  (command_if.source),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        command_t got;
        if (rst_n && command_if.valid && command_if.ready)
        begin
            got.drive_cmd   = command_if.drive_cmd;
            got.turn_cmd    = command_if.turn_cmd;
            got.upside_down = command_if.upside_down;
            sb.check(got);
        end
    end

    initial
    begin
        command_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && stall_odds > 0 && $urandom_range(0, 99) < stall_odds)
            begin
                command_if.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            command_if.ready <= 1'b1;
        end
    end

    task automatic send_sample(logic signed [ACCEL_W-1:0] x, logic signed [ACCEL_W-1:0] y,
                               logic signed [ACCEL_W-1:0] z);
        sample_if.valid   <= 1'b1;
        sample_if.accel_x <= x;
        sample_if.accel_y <= y;
        sample_if.accel_z <= z;
        do
            @(posedge clk);
        while (!sample_if.ready);
        sb.note(x, y, z);
        if (!calm && gap_odds > 0 && $urandom_range(0, 99) < gap_odds)
        begin
            sample_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic drain();
        sample_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [ACCEL_W-1:0] pick_axis(int mode);
        case (mode)
            0: return ACCEL_W'($urandom);
            1: return ACCEL_W'($signed($urandom_range(0, 4000)) - 2000);
            2: return ACCEL_W'($urandom_range(0, 1) ? 16'sh7FFF - $urandom_range(0, 3)
                                                      : 16'sh8000 + $urandom_range(0, 3));
            default: return ACCEL_W'($signed($urandom_range(0, 32000)) - 16000);
        endcase
    endfunction

    task automatic random_samples(int count);
        logic signed [ACCEL_W-1:0] x, y, z;
        int mode;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 5)
            begin
                z = ACCEL_W'($urandom_range(0, 1) ? $urandom_range(8000, 20000)
                                                  : -$signed($urandom_range(8000, 20000)));
                x = pick_axis(3);
                y = pick_axis(3);
            end
            else
            begin
                x = pick_axis($urandom_range(0, 3));
                y = pick_axis($urandom_range(0, 3));
                z = pick_axis($urandom_range(0, 3));
                if ($urandom_range(0, 7) == 0)
                    x = '0;
                if ($urandom_range(0, 7) == 0)
                    z = '0;
            end
            send_sample(x, y, z);
        end
    endtask

    initial
    begin
        int phase_max[8];
        int phase_full[8];
        phase_max  = '{60, 1, 90, 0, 127, 45, 30, 90};
        phase_full = '{1000, 1, 16383, 500, 16383, 0, 8000, 1};
        sb         = new();
        cycles     = 0;
        calm       = 1'b0;
        gap_odds   = 20;
        stall_odds = 20;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        sample_if.valid   = 1'b0;
        sample_if.accel_x = '0;
        sample_if.accel_y = '0;
        sample_if.accel_z = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd16384);
        send_sample(16'sd0, 16'sd0, -16'sd16384);
        send_sample(16'sd1, -16'sd1, 16'sd0);
        send_sample(-16'sd1, 16'sd1, 16'sd0);
        send_sample(16'sh7FFF, 16'sh8000, 16'sd1);
        send_sample(16'sh8000, 16'sh7FFF, -16'sd1);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF, 16'sh7FFF);
        send_sample(16'sd1000, -16'sd1000, 16'sd1000);
        send_sample(16'sd0, 16'sd5, -16'sd1);
        send_sample(-16'sd3, 16'sd0, -16'sd1);
        send_sample(-16'sd1, -16'sd1, -16'sd1);
        send_sample(16'shAAAA, 16'sh5555, 16'sh5555);
        send_sample(16'sh5555, 16'shAAAA, 16'shAAAA);
        send_sample(16'sd9459, -16'sd9459, 16'sd16384);
        send_sample(16'sd100, 16'sd200, 16'sd32767);

        for (int p = 0; p < 8; p++)
        begin
            drain();
            write_reg(REG_MAX_ANGLE, {7'($urandom), 7'(phase_max[p])});
            write_reg(REG_FULL_SCALE, CFG_DATA_W'(phase_full[p]));
            gap_odds   = (p % 3 == 1) ? 0 : $urandom_range(5, 40);
            stall_odds = (p % 3 == 2) ? 0 : $urandom_range(5, 40);
            calm       = (p == 7);
            send_sample(16'sd0, 16'sd0, 16'sd100);
            send_sample(16'sd0, 16'sd0, -16'sd100);
            random_samples(RANDOM_ITEMS / 8);
        end

        drain();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tdc_pkg.sv
rtl/tdc_in_if.sv
rtl/tdc_out_if.sv
rtl/tdc_front.sv
rtl/tdc_fifo.sv
rtl/tdc_cordic.sv
rtl/tdc_scale.sv
rtl/tdc_back.sv
rtl/tilt_to_drive_command_core.sv
tb/sv/testbench.sv
